>>> hw/rtl/sdpm_pkg.sv
// Shared types and constants for the stereo delay peak meter.
package sdpm_pkg;

    localparam int MAX_DELAY_SAMPLES = 4096;
    localparam int MAX_CHANNELS      = 8;
    localparam int DLY_AW            = $clog2(MAX_DELAY_SAMPLES);
    localparam int CH_POS_W          = $clog2(MAX_CHANNELS);
    localparam int CH_CNT_W          = 4;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;

    localparam logic [15:0] HALF_RANGE = 16'h8000;

    typedef enum logic [2:0] {
        FMT_S8  = 3'd0,
        FMT_S16 = 3'd1,
        FMT_S32 = 3'd2,
        FMT_U8  = 3'd3,
        FMT_U16 = 3'd4,
        FMT_U32 = 3'd5
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT   = 2'd0,
        CFG_CHANNELS = 2'd1,
        CFG_DELAY    = 2'd2,
        CFG_PERIOD   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CH_LEFT  = 2'd0,
        CH_RIGHT = 2'd1,
        CH_OTHER = 2'd2
    } t_chan;

    typedef struct packed {
        logic step;
        logic clear;
    } t_dly_ctl;

endpackage

>>> hw/rtl/stereo_delay_peak_meter_core.sv
// Top level: stereo delay peak meter with sample stream in and sample/report out.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------------
//  in      | i_in_valid / o_in_ready    | i_sample_in
//  out     | o_out_valid / i_out_ready  | o_sample_out, o_report_valid, o_left_peak,
//          |                            | o_right_peak
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the output is not stalled; each input beat passes
// the stage 1 register (delay RAM read) and then the output register (scale and peak stage).
// Reset is synchronous; the delay RAM needs no clearing pass, a wrap flag masks
// entries not written since reset or the last delay write.
// An output stall holds both stages; o_in_ready follows i_out_ready combinationally.
// Config writes are always taken.
module stereo_delay_peak_meter_core
    import sdpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_sample_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_sample_out,
    output logic                  o_report_valid,
    output logic [15:0]           o_left_peak,
    output logic [15:0]           o_right_peak,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    t_fmt                r_format;
    logic [CH_CNT_W-1:0] r_channels;
    logic [DLY_AW-1:0]   r_delay;
    logic [15:0]         r_period;

    // sequencing state
    logic [CH_POS_W-1:0] r_pos;
    logic [CH_POS_W-1:0] n_pos;
    logic [15:0]         r_frames;
    logic [15:0]         r_lpk;
    logic [15:0]         r_rpk;

    // stage 1
    logic                r_v1;
    logic [31:0]         r_raw1;
    t_chan               r_cls1;
    logic                r_dly1;

    // output register
    logic                r_ov;
    logic [31:0]         r_sample_o;
    logic                r_rep_o;
    logic [15:0]         r_lpk_o;
    logic [15:0]         r_rpk_o;

    logic                w_cfg_acc;
    logic                w_in_acc;
    logic                w_adv2;
    logic                w_fire1;
    logic [CH_CNT_W-1:0] w_count;
    logic [CH_CNT_W-1:0] w_pos_inc;
    t_chan               w_cls;
    t_dly_ctl            w_dly_ctl;
    logic [31:0]         w_held;
    logic                w_hit;
    logic [31:0]         w_sample;
    logic [15:0]         w_mag;
    logic [15:0]         w_lpk_new;
    logic [15:0]         w_rpk_new;
    logic [15:0]         w_frames_inc;
    logic                w_report;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    assign w_adv2     = !r_ov || i_out_ready;
    assign w_fire1    = r_v1 && w_adv2;
    assign o_in_ready = !r_v1 || w_adv2;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Effective channel count: zero acts as one, saturate at the maximum
    always_comb begin
        if (r_channels == '0) begin
            w_count = CH_CNT_W'(1);
        end else if (r_channels > CH_CNT_W'(MAX_CHANNELS)) begin
            w_count = CH_CNT_W'(MAX_CHANNELS);
        end else begin
            w_count = r_channels;
        end
    end

    assign w_pos_inc = {1'b0, r_pos} + CH_CNT_W'(1);
    assign n_pos     = (w_pos_inc >= w_count) ? '0 : w_pos_inc[CH_POS_W-1:0];

    always_comb begin
        if (r_pos == CH_POS_W'(0)) begin
            w_cls = CH_LEFT;
        end else if (r_pos == CH_POS_W'(1)) begin
            w_cls = CH_RIGHT;
        end else begin
            w_cls = CH_OTHER;
        end
    end

    assign w_dly_ctl.step  = w_in_acc && (w_cls == CH_RIGHT) && (r_delay != '0);
    assign w_dly_ctl.clear = w_cfg_acc && (t_cfg_idx'(i_cfg_index) == CFG_DELAY);

    sdpm_delay u_delay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dly_ctl),
        .i_depth (r_delay),
        .i_wdata (i_sample_in),
        .o_rdata (w_held),
        .o_hit   (w_hit)
    );

    // Unwritten delay entries read as zero
    assign w_sample = r_dly1 ? (w_hit ? w_held : 32'd0) : r_raw1;

    sdpm_scale u_scale (
        .i_raw    (w_sample),
        .i_format (r_format),
        .o_mag    (w_mag)
    );

    assign w_lpk_new    = (w_mag > r_lpk) ? w_mag : r_lpk;
    assign w_rpk_new    = (w_mag > r_rpk) ? w_mag : r_rpk;
    assign w_frames_inc = r_frames + 16'd1;
    assign w_report     = (r_cls1 == CH_LEFT) && (w_frames_inc == r_period);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format   <= FMT_S16;
            r_channels <= CH_CNT_W'(2);
            r_delay    <= '0;
            r_period   <= 16'd1024;
        end else if (w_cfg_acc) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FORMAT:   r_format   <= t_fmt'(i_cfg_data[2:0]);
                CFG_CHANNELS: r_channels <= i_cfg_data[CH_CNT_W-1:0];
                CFG_DELAY:    r_delay    <= i_cfg_data[DLY_AW-1:0];
                CFG_PERIOD:   r_period   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stage 1: channel position and delay RAM access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_v1  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_pos <= n_pos;
                r_v1  <= 1'b1;
            end else if (w_fire1) begin
                r_v1  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_raw1 <= i_sample_in;
            r_cls1 <= w_cls;
            r_dly1 <= (w_cls == CH_RIGHT) && (r_delay != '0);
        end
    end

    // stage 2: peak holds and frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
            r_lpk    <= '0;
            r_rpk    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (w_adv2) begin
                r_ov <= r_v1;
            end
            if (w_fire1) begin
                case (r_cls1)
                    CH_LEFT: begin
                        if (w_report) begin
                            r_frames <= '0;
                            r_lpk    <= '0;
                            r_rpk    <= '0;
                        end else begin
                            r_frames <= w_frames_inc;
                            r_lpk    <= w_lpk_new;
                        end
                    end
                    CH_RIGHT: r_rpk <= w_rpk_new;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire1) begin
            r_sample_o <= w_sample;
            r_rep_o    <= w_report;
            r_lpk_o    <= w_report ? w_lpk_new : 16'd0;
            r_rpk_o    <= w_report ? r_rpk : 16'd0;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_sample_out   = r_sample_o;
    assign o_report_valid = r_rep_o;
    assign o_left_peak    = r_lpk_o;
    assign o_right_peak   = r_rpk_o;

    a_peaks_zero_without_report : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |-> (o_left_peak == 16'd0 && o_right_peak == 16'd0)
    ) else $error("peak fields nonzero on a beat without report");

    a_peak_hold_range : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_lpk <= HALF_RANGE) && (r_rpk <= HALF_RANGE)
    ) else $error("peak hold above full scale");

    a_ready_only_on_stall : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_ov && !i_out_ready && r_v1)
    ) else $error("input stalled without output backpressure");

    a_stage1_drains : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_adv2) |=> o_out_valid
    ) else $error("stage 1 beat lost on advance");

endmodule

>>> hw/rtl/sdpm_scale.sv
// Sample scaling to the 16-bit range and magnitude extraction.
module sdpm_scale
    import sdpm_pkg::*;
(
    input  logic [31:0] i_raw,
    input  t_fmt        i_format,
    output logic [15:0] o_mag
);

    logic [31:0] w_wide;
    logic [15:0] w_hi;
    logic [15:0] w_lo;
    logic [15:0] w_quot;
    logic [7:0]  w_byte;
    logic [15:0] w_ofs;

    // x / 65537 == hi - (lo < hi) for any 32-bit x
    assign w_wide = (i_format == FMT_S32) ? (i_raw ^ 32'h8000_0000) : i_raw;
    assign w_hi   = w_wide[31:16];
    assign w_lo   = w_wide[15:0];
    assign w_quot = w_hi - {15'd0, (w_lo < w_hi)};
    assign w_byte = i_raw[7:0];

    // Offset-binary value: signed result is w_ofs - 32768
    always_comb begin
        case (i_format)
            FMT_S8:  w_ofs = {w_byte ^ 8'h80, w_byte ^ 8'h80};
            FMT_S32: w_ofs = w_quot;
            FMT_U8:  w_ofs = {w_byte, w_byte};
            FMT_U16: w_ofs = i_raw[15:0];
            FMT_U32: w_ofs = w_quot;
            default: w_ofs = i_raw[15:0] ^ HALF_RANGE;
        endcase
    end

    assign o_mag = w_ofs[15] ? {1'b0, w_ofs[14:0]} : (HALF_RANGE - w_ofs);

endmodule

>>> hw/rtl/sdpm_delay.sv
// Right channel circular delay line with fill tracking.
module sdpm_delay
    import sdpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dly_ctl          i_ctl,
    input  logic [DLY_AW-1:0] i_depth,
    input  logic [31:0]       i_wdata,
    output logic [31:0]       o_rdata,
    output logic              o_hit
);

    logic [31:0]       r_mem [MAX_DELAY_SAMPLES];
    logic [31:0]       r_rdata;
    logic              r_hit;
    logic [DLY_AW-1:0] r_ptr;
    logic [DLY_AW-1:0] n_ptr;
    logic              r_wrapped;
    logic [DLY_AW:0]   w_ptr_inc;
    logic              w_wrap;

    assign w_ptr_inc = {1'b0, r_ptr} + {{DLY_AW{1'b0}}, 1'b1};
    assign w_wrap    = (w_ptr_inc >= {1'b0, i_depth});
    assign n_ptr     = w_wrap ? '0 : w_ptr_inc[DLY_AW-1:0];

    // Read-first single port: old entry out, new sample in
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_rdata      <= r_mem[r_ptr];
            r_mem[r_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_wrapped <= 1'b0;
            r_hit     <= 1'b0;
        end else if (i_ctl.clear) begin
            r_ptr     <= '0;
            r_wrapped <= 1'b0;
        end else if (i_ctl.step) begin
            // Entry holds a real sample only once the line has come round
            r_hit <= r_wrapped;
            r_ptr <= n_ptr;
            if (w_wrap) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_hit   = r_hit;

endmodule

>>> sim/tb_stereo_delay_peak_meter_core.sv
// Testbench for the stereo delay peak meter core: directed and random sample streams.
`timescale 1ns / 1ps

module tb_stereo_delay_peak_meter_core;
    import sdpm_pkg::*;

    typedef struct packed {
        logic [31:0] sample;
        logic        report;
        logic [15:0] lpk;
        logic [15:0] rpk;
    } t_meter_beat;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [31:0]           i_sample_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [31:0]           o_sample_out;
    logic                  o_report_valid;
    logic [15:0]           o_left_peak;
    logic [15:0]           o_right_peak;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stereo_delay_peak_meter_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out),
        .o_report_valid (o_report_valid),
        .o_left_peak    (o_left_peak),
        .o_right_peak   (o_right_peak),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Meter state as the block should hold it
    logic [2:0]  fmt_q;
    logic [3:0]  chan_q;
    logic [11:0] dly_q;
    logic [15:0] period_q;
    logic [31:0] dly_line [0:MAX_DELAY_SAMPLES-1];
    int          dly_ptr;
    int          chan_pos;
    logic [15:0] frame_cnt;
    logic [15:0] lpk_hold;
    logic [15:0] rpk_hold;

    t_meter_beat expected_beats [$];

    int in_idle_pct;
    int out_stall_pct;
    int ready_hold;
    int fail_count;
    int samples_in;
    int beats_out;
    int reports_seen;
    int cfg_writes;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int scale_to_s16(logic [2:0] fmt, logic [31:0] raw);
        logic [31:0] q;
        case (t_fmt'(fmt))
            FMT_S8:  return int'({24'd0, raw[7:0] ^ 8'h80}) * 257 - 32768;
            FMT_S32: begin
                q = (raw ^ 32'h8000_0000) / 32'd65537;
                return int'(q) - 32768;
            end
            FMT_U8:  return int'({24'd0, raw[7:0]}) * 257 - 32768;
            FMT_U16: return int'({16'd0, raw[15:0]}) - 32768;
            FMT_U32: begin
                q = raw / 32'd65537;
                return int'(q) - 32768;
            end
            // s16 and the two unused codes
            default: return int'({16'd0, raw[15:0] ^ 16'h8000}) - 32768;
        endcase
    endfunction

    function automatic void clear_delay_line();
        for (int k = 0; k < MAX_DELAY_SAMPLES; k++) dly_line[k] = 32'd0;
        dly_ptr = 0;
    endfunction

    function automatic void meter_reset();
        fmt_q     = FMT_S16;
        chan_q    = 4'd2;
        dly_q     = 12'd0;
        period_q  = 16'd1024;
        chan_pos  = 0;
        frame_cnt = 16'd0;
        lpk_hold  = 16'd0;
        rpk_hold  = 16'd0;
        clear_delay_line();
    endfunction

    function automatic void meter_config(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (t_cfg_idx'(idx))
            CFG_FORMAT:   fmt_q = data[2:0];
            CFG_CHANNELS: chan_q = data[3:0];
            CFG_DELAY: begin
                dly_q = data[11:0];
                clear_delay_line();
            end
            CFG_PERIOD:   period_q = data;
            default: ;
        endcase
    endfunction

    function automatic t_meter_beat meter_predict(logic [31:0] raw_in);
        t_meter_beat r;
        logic [31:0] raw;
        logic [31:0] held;
        int          count;
        int          depth;
        int          s;
        int          mag;
        r     = '0;
        raw   = raw_in;
        count = int'(chan_q);
        if (count == 0) count = 1;
        if (count > MAX_CHANNELS) count = MAX_CHANNELS;
        depth = int'(dly_q);
        if (depth > MAX_DELAY_SAMPLES) depth = MAX_DELAY_SAMPLES;

        if (chan_pos == 1 && depth != 0) begin
            if (dly_ptr >= depth) dly_ptr = 0;
            held = dly_line[dly_ptr];
            dly_line[dly_ptr] = raw;
            raw = held;
            dly_ptr++;
            if (dly_ptr >= depth) dly_ptr = 0;
        end

        s   = scale_to_s16(fmt_q, raw);
        mag = (s < 0) ? -s : s;

        if (chan_pos == 0) begin
            if (mag > int'(lpk_hold)) lpk_hold = 16'(mag);
            frame_cnt = frame_cnt + 16'd1;
            if (frame_cnt == period_q) begin
                r.report  = 1'b1;
                r.lpk     = lpk_hold;
                r.rpk     = rpk_hold;
                frame_cnt = 16'd0;
                lpk_hold  = 16'd0;
                rpk_hold  = 16'd0;
            end
        end else if (chan_pos == 1) begin
            if (mag > int'(rpk_hold)) rpk_hold = 16'(mag);
        end

        chan_pos++;
        if (chan_pos >= count) chan_pos = 0;
        r.sample = raw;
        return r;
    endfunction

    task automatic log_beat_error(string what, t_meter_beat want, t_meter_beat got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t %s: expected sample %h rep %b L %0d R %0d, got sample %h rep %b L %0d R %0d",
                     $time, what, want.sample, want.report, want.lpk, want.rpk,
                     got.sample, got.report, got.lpk, got.rpk);
        end
    endtask

    // Predict on input beats, compare on output beats
    always @(posedge i_clk) begin : beat_monitor
        t_meter_beat got;
        t_meter_beat want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                meter_config(i_cfg_index, i_cfg_data);
                cfg_writes++;
            end
            if (i_in_valid && o_in_ready) begin
                expected_beats.push_back(meter_predict(i_sample_in));
                samples_in++;
            end
            if (o_out_valid && i_out_ready) begin
                got.sample = o_sample_out;
                got.report = o_report_valid;
                got.lpk    = o_left_peak;
                got.rpk    = o_right_peak;
                beats_out++;
                if (expected_beats.size() == 0) begin
                    log_beat_error("unexpected beat", '0, got);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.sample != want.sample || got.report != want.report ||
                        got.lpk != want.lpk || got.rpk != want.rpk) begin
                        log_beat_error("beat mismatch", want, got);
                    end
                    if (want.report) reports_seen++;
                end
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic set_idling(t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin in_idle_pct = 0;  out_stall_pct = 0;  end
            IDLE_SENDER:   begin in_idle_pct = 60; out_stall_pct = 0;  end
            IDLE_RECEIVER: begin in_idle_pct = 0;  out_stall_pct = 60; end
            default:       begin in_idle_pct = 6;  out_stall_pct = 6;  end
        endcase
    endtask

    // Called and returns at a falling edge
    task automatic send_sample(input logic [31:0] data);
        // Each idle step gets its own draw so the idle share matches the percentage
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            4: begin
                case ($urandom_range(3))
                    0:       r = 32'h0000_0000;
                    1:       r = 32'hFFFF_FFFF;
                    2:       r = 32'h8000_0000;
                    default: r = 32'h7FFF_FFFF;
                endcase
            end
            5: r[15:0] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            6: r[7:0] = $urandom_range(1) ? 8'h80 : 8'h7F;
            7: r[31:16] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: ;
        endcase
        return r;
    endfunction

    task automatic rand_settings();
        logic [15:0] junk;
        logic [3:0]  chans;
        logic [11:0] depth;
        logic [15:0] period;
        junk = 16'($urandom);
        case ($urandom_range(5))
            0:       chans = 4'd0;
            1:       chans = 4'd1;
            2:       chans = 4'd2;
            3:       chans = 4'd8;
            4:       chans = 4'd15;
            default: chans = 4'($urandom_range(15));
        endcase
        case ($urandom_range(5))
            0:       depth = 12'd0;
            1:       depth = 12'd1;
            2:       depth = 12'd2;
            3:       depth = 12'd5;
            default: depth = 12'($urandom_range(64, 1));
        endcase
        case ($urandom_range(6))
            0:       period = 16'd1;
            1:       period = 16'd2;
            2:       period = 16'd3;
            3:       period = 16'hFFFF;
            4:       period = 16'd0;
            default: period = 16'($urandom_range(10, 1));
        endcase
        // Unused upper data bits get random values
        cfg_write(CFG_FORMAT, {junk[15:3], 3'($urandom_range(7))});
        cfg_write(CFG_CHANNELS, {junk[11:0], chans});
        cfg_write(CFG_DELAY, {junk[15:12], depth});
        cfg_write(CFG_PERIOD, period);
    endtask

    task automatic test_reset_values();
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_format_codes();
        cfg_write(CFG_PERIOD, 16'd2);
        for (int f = 0; f < 8; f++) begin
            cfg_write(CFG_FORMAT, 16'(f));
            send_sample(32'h8000_8080);
            send_sample(32'h7FFF_7F7F);
            drain_results();
        end
    endtask

    task automatic test_channel_lowering();
        cfg_write(CFG_CHANNELS, 16'd8);
        repeat (5) send_sample(rand_sample());
        drain_results();
        // Position now sits above the new count
        cfg_write(CFG_CHANNELS, 16'd2);
        repeat (3) send_sample(rand_sample());
        drain_results();
    endtask

    task automatic test_backpressure();
        cfg_write(CFG_FORMAT, 16'(FMT_S32));
        cfg_write(CFG_CHANNELS, 16'd2);
        cfg_write(CFG_DELAY, 16'd2);
        cfg_write(CFG_PERIOD, 16'd3);
        set_idling(IDLE_NONE);
        ready_hold = 200;
        repeat (40) send_sample(rand_sample());
        // Hold the sender until everything has come out
        drain_results();
        set_idling(IDLE_BOTH);
        repeat (20) send_sample(rand_sample());
        drain_results();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 8; p++) begin
            rand_settings();
            set_idling(t_idle_mode'(p % 4));
            repeat (120) send_sample(rand_sample());
            drain_results();
        end
    endtask

    task automatic test_long_delay();
        cfg_write(CFG_FORMAT, 16'(FMT_U16));
        cfg_write(CFG_CHANNELS, 16'd2);
        cfg_write(CFG_DELAY, 16'd300);
        cfg_write(CFG_PERIOD, 16'd500);
        set_idling(IDLE_NONE);
        repeat (640) send_sample(rand_sample());
        drain_results();
    endtask

    task automatic test_counter_wrap();
        cfg_write(CFG_CHANNELS, 16'd1);
        cfg_write(CFG_DELAY, 16'd7);
        // Land a report on the next frame to start from a zero count
        cfg_write(CFG_PERIOD, frame_cnt + 16'd1);
        set_idling(IDLE_NONE);
        send_sample(rand_sample());
        drain_results();
        cfg_write(CFG_PERIOD, 16'd1000);
        repeat (10) send_sample(rand_sample());
        drain_results();
        // Period below the count: no report until the counter comes round
        cfg_write(CFG_PERIOD, 16'd4);
        repeat (20) send_sample(rand_sample());
        drain_results();
        cfg_write(CFG_PERIOD, 16'd0);
        repeat (20) send_sample(rand_sample());
        drain_results();
    endtask

    initial begin
        int waited;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_sample_in   = 32'd0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_FORMAT;
        i_cfg_data    = 16'd0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        ready_hold    = 0;
        fail_count    = 0;
        samples_in    = 0;
        beats_out     = 0;
        reports_seen  = 0;
        cfg_writes    = 0;
        meter_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_format_codes();
        test_channel_lowering();
        test_backpressure();
        test_random_phases();
        test_long_delay();
        test_counter_wrap();

        set_idling(IDLE_NONE);
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_beats.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
        if (expected_beats.size() != 0) begin
            fail_count += expected_beats.size();
            $display("%0d expected beats never arrived", expected_beats.size());
        end

        $display("Covered %0d samples and %0d output beats with %0d peak reports,",
                 samples_in, beats_out, reports_seen);
        $display("over %0d register writes (all formats, channel and delay extremes, short periods).",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("[stereo_delay_peak_meter_core] OK");
        end else begin
            $display("[stereo_delay_peak_meter_core] ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timed out waiting for the block");
        $display("[stereo_delay_peak_meter_core] ERROR");
        $finish;
    end

endmodule

>>> stereo_delay_peak_meter_core.f
hw/rtl/sdpm_pkg.sv
hw/rtl/sdpm_scale.sv
hw/rtl/sdpm_delay.sv
hw/rtl/stereo_delay_peak_meter_core.sv
sim/tb_stereo_delay_peak_meter_core.sv
